[sv/softening_curve_energy_integrator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the softening curve energy integrator
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef SOFTENING_CURVE_ENERGY_INTEGRATOR_CORE_ASSERT_SVH
`define SOFTENING_CURVE_ENERGY_INTEGRATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCEI_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define SCEI_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SCEI_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SCEI_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

[sv/scei_pkg.sv]
// ----------------------------------------------------------------------------
// scei_pkg
// Widths, codes and controller/datapath interface types of the integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scei_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int ACC_W       = 64;
    localparam int THRESH_W    = 31;
    localparam int AREA_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 2 * SAMPLE_W;
    localparam int OUT_TDATA_W = ACC_W;
    localparam int OUT_TUSER_W = 8;
    localparam int MUL_A_W     = SAMPLE_W + 1;
    localparam int MUL_P_W     = MUL_A_W + SAMPLE_W;

    localparam logic [AREA_W-1:0] AREA_RESET = 32'h0001_0000;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AREA   = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_FIRST_NZ  = 3'd1;
    localparam status_t STATUS_ABOVE     = 3'd2;
    localparam status_t STATUS_NO_CROSS  = 3'd3;
    localparam status_t STATUS_ZERO_AREA = 3'd4;

    typedef enum logic [1:0] {
        MUL_TRAP  = 2'd0,
        MUL_CROSS = 2'd1,
        MUL_PART  = 2'd2
    } mul_sel_t;

    typedef enum logic {
        DIV_CROSS = 1'b0,
        DIV_FINAL = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     chk_first;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     cross_set;
        logic     acc_en;
        logic     post_en;
        logic     out_wr;
        logic     run_clear;
    } cmd_t;

    typedef struct packed {
        logic first_pending;
        logic mode;
        logic crossing_done;
        logic cross_hit;
        logic last;
        logic div_busy;
        logic div_done;
        logic out_free;
        logic final_ok;
    } sts_t;

endpackage

[sv/scei_div.sv]
// ----------------------------------------------------------------------------
// scei_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scei_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [scei_pkg::ACC_W-1:0]   num,
    input  logic [scei_pkg::AREA_W-1:0]  den,
    output logic                         busy,
    output logic                         done,
    output logic [scei_pkg::ACC_W-1:0]   quot
);

    localparam int Q_W   = scei_pkg::ACC_W;
    localparam int D_W   = scei_pkg::AREA_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   quot_reg;

    logic [D_W:0] rem_shift;
    logic [D_W:0] rem_diff;
    logic         fits;

    assign rem_shift = {rem_reg, quot_reg[Q_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(Q_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // dividend shifts out of the top of quot_reg as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (cnt_reg != '0) begin
            rem_reg  <= fits ? rem_diff[D_W-1:0] : rem_shift[D_W-1:0];
            quot_reg <= {quot_reg[Q_W-2:0], fits};
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[sv/scei_ctrl.sv]
// ----------------------------------------------------------------------------
// scei_ctrl
// Sequencer: walks each request through evaluate, then as needed divide,
// multiply, accumulate and post, then the end-of-run division and output write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "softening_curve_energy_integrator_core_assert.svh"

module scei_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  scei_pkg::sts_t sts,
    output scei_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_EVAL = 9'b000000010,
        ST_DIVX = 9'b000000100,
        ST_MULP = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_POST = 9'b000100000,
        ST_FIN  = 9'b001000000,
        ST_DIVF = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (sts.first_pending) begin
                    cmd.chk_first = 1'b1;
                    state_next    = ST_POST;
                end else if (!sts.mode) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = scei_pkg::MUL_TRAP;
                    state_next  = ST_ACC;
                end else if (sts.crossing_done) begin
                    state_next = ST_POST;
                end else if (sts.cross_hit) begin
                    // product feeds the divider directly
                    cmd.mul_sel   = scei_pkg::MUL_CROSS;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = scei_pkg::DIV_CROSS;
                    state_next    = ST_DIVX;
                end else begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = scei_pkg::MUL_TRAP;
                    state_next  = ST_ACC;
                end
            end
            ST_DIVX: begin
                if (sts.div_done) begin
                    state_next = ST_MULP;
                end
            end
            ST_MULP: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = scei_pkg::MUL_PART;
                cmd.cross_set = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = ST_POST;
            end
            ST_POST: begin
                cmd.post_en = 1'b1;
                state_next  = sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (sts.final_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = scei_pkg::DIV_FINAL;
                    state_next    = ST_DIVF;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVF: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_wr    = 1'b1;
                    cmd.run_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SCEI_ASSERT_IMP(a_div_start_idle, aclk, aresetn, cmd.div_start, !sts.div_busy)
    `SCEI_ASSERT_IMP(a_accept_div_idle, aclk, aresetn, cmd.load_in, !sts.div_busy)
    `SCEI_ASSERT_NXT(a_clear_then_ready, aclk, aresetn, cmd.run_clear, s_tready)

endmodule

[sv/scei_dp.sv]
// ----------------------------------------------------------------------------
// scei_dp
// Datapath: configuration registers, sample magnitudes, shared multiplier,
// saturating Q32.32 accumulator, divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "softening_curve_energy_integrator_core_assert.svh"

module scei_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [scei_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [scei_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [scei_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scei_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [scei_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  scei_pkg::cmd_t                       cmd,
    output scei_pkg::sts_t                       sts
);

    localparam int SW  = scei_pkg::SAMPLE_W;
    localparam int AW  = scei_pkg::ACC_W;
    localparam int TW  = scei_pkg::THRESH_W;
    localparam int MAW = scei_pkg::MUL_A_W;
    localparam int MPW = scei_pkg::MUL_P_W;

    // configuration
    logic                         mode_reg;
    logic [TW-1:0]                thresh_reg;
    logic [scei_pkg::AREA_W-1:0]  area_reg;

    // current request
    logic [SW-1:0] f_reg;
    logic [SW-1:0] d_reg;
    logic          last_reg;

    // run state
    logic [SW-1:0] pf_reg;
    logic [SW-1:0] pd_reg;
    logic [AW-1:0] integral_reg;
    logic          first_pending_reg;
    logic          crossing_done_reg;
    logic          above_seen_reg;
    logic          err_first_reg;

    logic [AW-1:0] prod_reg;

    logic                      m_tvalid_reg;
    logic [AW-1:0]             m_energy_reg;
    scei_pkg::status_t         m_status_reg;

    logic [SW-1:0]     f_mag;
    logic [SW-1:0]     d_mag;
    logic [SW-1:0]     t_ext;
    logic              disp_neg;
    logic [SW-1:0]     dd;
    logic              cross_hit;
    logic [MAW-1:0]    mul_a;
    logic [SW-1:0]     mul_b;
    logic [MPW-1:0]    mul_full;
    logic [AW-1:0]     half;
    logic [AW-1:0]     addend;
    logic [AW:0]       sum;
    logic [AW-1:0]     integral_next;
    logic [AW-1:0]     int_mag;
    logic [AW-1:0]     div_num;
    logic [SW-1:0]     div_den;
    logic              div_busy;
    logic              div_done;
    logic [AW-1:0]     div_quot;
    scei_pkg::status_t final_status;
    logic [AW-1:0]     energy;
    logic              out_free;

    // magnitudes; the most negative code maps to 2^(SW-1) as unsigned
    assign f_mag = s_tdata[SW-1] ? (SW'(0) - s_tdata[SW-1:0]) : s_tdata[SW-1:0];
    assign d_mag = s_tdata[2*SW-1] ? (SW'(0) - s_tdata[2*SW-1:SW]) : s_tdata[2*SW-1:SW];

    assign t_ext     = {{(SW-TW){1'b0}}, thresh_reg};
    assign disp_neg  = (d_reg < pd_reg);
    assign dd        = disp_neg ? (pd_reg - d_reg) : (d_reg - pd_reg);
    assign cross_hit = above_seen_reg && (pf_reg > t_ext) && (f_reg <= t_ext);

    always_comb begin
        unique case (cmd.mul_sel)
            scei_pkg::MUL_TRAP: begin
                mul_a = {1'b0, pf_reg} + {1'b0, f_reg};
                mul_b = dd;
            end
            scei_pkg::MUL_CROSS: begin
                mul_a = {1'b0, dd};
                mul_b = pf_reg - t_ext;
            end
            scei_pkg::MUL_PART: begin
                mul_a = {1'b0, t_ext} + {1'b0, pf_reg};
                mul_b = div_quot[SW-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = MPW'(mul_a) * MPW'(mul_b);

    // half trapezoid, sign from the displacement step, saturating add
    assign half   = {1'b0, prod_reg[AW-1:1]};
    assign addend = disp_neg ? (AW'(0) - half) : half;
    assign sum    = {integral_reg[AW-1], integral_reg} + {addend[AW-1], addend};

    always_comb begin
        priority if (sum[AW] != sum[AW-1]) begin
            integral_next = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            integral_next = sum[AW-1:0];
        end
    end

    assign int_mag = integral_reg[AW-1] ? (AW'(0) - integral_reg) : integral_reg;
    assign div_num = (cmd.div_sel == scei_pkg::DIV_CROSS) ? mul_full[AW-1:0] : int_mag;
    assign div_den = (cmd.div_sel == scei_pkg::DIV_CROSS) ? (pf_reg - f_reg) : area_reg;

    scei_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        priority if (err_first_reg) begin
            final_status = scei_pkg::STATUS_FIRST_NZ;
        end else if (mode_reg && above_seen_reg) begin
            final_status = scei_pkg::STATUS_ABOVE;
        end else if (mode_reg && !crossing_done_reg) begin
            final_status = scei_pkg::STATUS_NO_CROSS;
        end else if (area_reg == '0) begin
            final_status = scei_pkg::STATUS_ZERO_AREA;
        end else begin
            final_status = scei_pkg::STATUS_OK;
        end
    end

    assign energy   = integral_reg[AW-1] ? (AW'(0) - div_quot) : div_quot;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            thresh_reg <= '0;
            area_reg   <= scei_pkg::AREA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                scei_pkg::CFG_MODE:   mode_reg   <= cfg_wdata[0];
                scei_pkg::CFG_THRESH: thresh_reg <= cfg_wdata[TW-1:0];
                scei_pkg::CFG_AREA:   area_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_reg            <= '0;
            pd_reg            <= '0;
            integral_reg      <= '0;
            first_pending_reg <= 1'b1;
            crossing_done_reg <= 1'b0;
            above_seen_reg    <= 1'b0;
            err_first_reg     <= 1'b0;
        end else if (cmd.run_clear) begin
            pf_reg            <= '0;
            pd_reg            <= '0;
            integral_reg      <= '0;
            first_pending_reg <= 1'b1;
            crossing_done_reg <= 1'b0;
            above_seen_reg    <= 1'b0;
            err_first_reg     <= 1'b0;
        end else begin
            if (cmd.chk_first && ((f_reg != '0) || (d_reg != '0))) begin
                err_first_reg <= 1'b1;
            end
            if (cmd.cross_set) begin
                crossing_done_reg <= 1'b1;
            end
            if (cmd.acc_en) begin
                integral_reg <= integral_next;
            end
            if (cmd.post_en) begin
                pf_reg            <= f_reg;
                pd_reg            <= d_reg;
                above_seen_reg    <= (f_reg > t_ext);
                first_pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_wr) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            f_reg    <= f_mag;
            d_reg    <= d_mag;
            last_reg <= s_tlast;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_full[AW-1:0];
        end
        if (cmd.out_wr) begin
            m_status_reg <= final_status;
            m_energy_reg <= (final_status == scei_pkg::STATUS_OK) ? energy : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_energy_reg;
    assign m_tuser  = {{(scei_pkg::OUT_TUSER_W-scei_pkg::STATUS_W){1'b0}}, m_status_reg};

    assign sts.first_pending = first_pending_reg;
    assign sts.mode          = mode_reg;
    assign sts.crossing_done = crossing_done_reg;
    assign sts.cross_hit     = cross_hit;
    assign sts.last          = last_reg;
    assign sts.div_busy      = div_busy;
    assign sts.div_done      = div_done;
    assign sts.out_free      = out_free;
    assign sts.final_ok      = (final_status == scei_pkg::STATUS_OK);

    `SCEI_ASSERT_NXT(a_run_cleared, aclk, aresetn, cmd.run_clear, (integral_reg == '0) && first_pending_reg)
    `SCEI_ASSERT_IMP(a_acc_not_first, aclk, aresetn, cmd.acc_en, !first_pending_reg)
    `SCEI_ASSERT_IMP(a_final_div_area, aclk, aresetn, cmd.div_start && (cmd.div_sel == scei_pkg::DIV_FINAL), area_reg != '0)

endmodule

[sv/softening_curve_energy_integrator_core.sv]
// ----------------------------------------------------------------------------
// softening_curve_energy_integrator_core
// Ordinary sample: evaluate and trapezoid multiply, accumulate, post; first
// sample and samples after the crossing: evaluate, post; crossing sample:
// divide, partial multiply, accumulate, post. Last sample: 64-step final
// divide unless the status is an error, result write once the output is free;
// next request accepted in the cycle after the write. Synchronous active-low
// reset clears control, config, run state, output valid; cross_area = 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module softening_curve_energy_integrator_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [scei_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [scei_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [scei_pkg::IN_TDATA_W-1:0]      s_tdata,   // force_sample, displacement_sample
    input  logic                                 s_tlast,   // last_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scei_pkg::OUT_TDATA_W-1:0]     m_tdata,   // energy
    output logic [scei_pkg::OUT_TUSER_W-1:0]     m_tuser    // status, zero fill
);

    scei_pkg::cmd_t cmd;
    scei_pkg::sts_t sts;

    scei_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scei_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[tb/sv/tb_softening_curve_energy_integrator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softening_curve_energy_integrator_core
// Self-checking bench for the energy integrator. Drives runs of force and
// displacement samples, predicts energy and status for every run from its
// own model of the datapath, and checks each result in order of arrival.
// ----------------------------------------------------------------------------

module tb_softening_curve_energy_integrator_core;
    import scei_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 80;     // final divide plus margin
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASES        = 30;
    localparam int PHASE_ITEMS   = 31;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int TIMEOUT_NS    = 8_000_000;

    localparam logic [63:0] FULL_SCALE = 64'h8000_0000;   // |most negative sample|
    localparam logic [31:0] FULL_CODE  = 32'h8000_0000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = CFG_MODE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // force_sample, displacement_sample
    logic                   s_tlast   = 1'b0; // last_sample
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // energy
    logic [OUT_TUSER_W-1:0] m_tuser;          // status, zero fill

    softening_curve_energy_integrator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    typedef struct {
        logic [ACC_W-1:0] energy;
        status_t          status;
    } energy_result_t;

    class energy_scoreboard;
        logic                mode;
        logic [THRESH_W-1:0] thresh;
        logic [AREA_W-1:0]   area;
        logic [63:0]         integral;     // Q32.32, saturating
        logic [63:0]         prev_force;
        logic [63:0]         prev_disp;
        logic                first_pending;
        logic                crossed;
        logic                was_above;
        status_t             run_error;
        energy_result_t      expected_energy_q[$];
        int unsigned         errors;

        function new();
            mode   = 1'b0;
            thresh = '0;
            area   = AREA_RESET;
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            integral      = '0;
            prev_force    = '0;
            prev_disp     = '0;
            first_pending = 1'b1;
            crossed       = 1'b0;
            was_above     = 1'b0;
            run_error     = STATUS_OK;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MODE:   mode   = value[0];
                CFG_THRESH: thresh = value[THRESH_W-1:0];
                CFG_AREA:   area   = value[AREA_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] magnitude(logic [SAMPLE_W-1:0] raw);
            if (raw[SAMPLE_W-1])
                return 64'd0 - {{(64-SAMPLE_W){1'b1}}, raw};
            return {{(64-SAMPLE_W){1'b0}}, raw};
        endfunction

        // (force_sum * step) / 2, truncated, clamped to the signed range, signed by the step direction
        function logic [63:0] half_area(logic [63:0] force_sum, logic neg, logic [63:0] step);
            logic [127:0] prod;
            logic [127:0] limit;
            prod  = ({64'd0, force_sum} * {64'd0, step}) >> 1;
            limit = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
            if (prod > limit)
                prod = limit;
            return neg ? 64'd0 - prod[63:0] : prod[63:0];
        endfunction

        function void accumulate(logic [63:0] add);
            logic [63:0] sum;
            sum = integral + add;
            if (integral[63] == add[63] && sum[63] != add[63])
                sum = add[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            integral = sum;
        endfunction

        function void note_sample(logic [IN_TDATA_W-1:0] data, logic last);
            logic [63:0]    f;
            logic [63:0]    d;
            logic [63:0]    t;
            logic [63:0]    step;
            logic [63:0]    mag_int;
            logic [63:0]    quot;
            logic [127:0]   scaled;
            logic           neg;
            energy_result_t r;
            f = magnitude(data[SAMPLE_W-1:0]);
            d = magnitude(data[IN_TDATA_W-1:SAMPLE_W]);
            t = {{(64-THRESH_W){1'b0}}, thresh};
            if (first_pending) begin
                if ((f != 0 || d != 0) && run_error == STATUS_OK)
                    run_error = STATUS_FIRST_NZ;
                first_pending = 1'b0;
            end else begin
                neg  = d < prev_disp;
                step = neg ? prev_disp - d : d - prev_disp;
                if (!mode) begin
                    accumulate(half_area(prev_force + f, neg, step));
                end else if (!crossed) begin
                    if (was_above && prev_force > t && f <= t) begin
                        // partial trapezoid up to the interpolated crossing point
                        scaled = ({64'd0, step} * {64'd0, prev_force - t})
                                 / {64'd0, prev_force - f};
                        accumulate(half_area(t + prev_force, neg, scaled[63:0]));
                        crossed = 1'b1;
                    end else begin
                        accumulate(half_area(prev_force + f, neg, step));
                    end
                end
            end
            prev_force = f;
            prev_disp  = d;
            was_above  = f > t;
            if (last) begin
                r.status = run_error;
                if (r.status == STATUS_OK && mode) begin
                    if (f > t)
                        r.status = STATUS_ABOVE;
                    else if (!crossed)
                        r.status = STATUS_NO_CROSS;
                end
                if (r.status == STATUS_OK && area == 0)
                    r.status = STATUS_ZERO_AREA;
                r.energy = '0;
                if (r.status == STATUS_OK) begin
                    mag_int  = integral[63] ? 64'd0 - integral : integral;
                    quot     = mag_int / {32'd0, area};
                    r.energy = integral[63] ? 64'd0 - quot : quot;
                end
                expected_energy_q.push_back(r);
                clear_run();
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] energy,
                                   logic [OUT_TUSER_W-1:0] user);
            energy_result_t         r;
            logic [OUT_TUSER_W-1:0] want_user;
            if (expected_energy_q.size() == 0) begin
                $error("unexpected result: energy %0d, status %0d", $signed(energy), user);
                errors++;
                return;
            end
            r         = expected_energy_q.pop_front();
            want_user = '0;
            want_user[STATUS_W-1:0] = r.status;
            if (energy !== r.energy) begin
                $error("energy: expected %0d, got %0d", $signed(r.energy), $signed(energy));
                errors++;
            end
            if (user !== want_user) begin
                $error("status: expected %0d, got %0d", want_user, user);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_energy_q.size();
        endfunction

        function void report_leftover();
            if (expected_energy_q.size() != 0) begin
                $error("%0d expected results never arrived", expected_energy_q.size());
                errors += expected_energy_q.size();
            end
        endfunction
    endclass

    energy_scoreboard    sb;
    int                  send_idle_pct = 26;
    int                  recv_idle_pct = 48;
    int                  hold_reqs     = 0;
    int                  hold_served   = 0;
    int                  hold_left     = 0;
    logic                cur_mode      = 1'b0;
    logic [THRESH_W-1:0] cur_thresh    = '0;

    // receiver: random backpressure, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.write_reg(cfg_addr, cfg_wdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tlast);
        end
    end

    task automatic send_sample(input logic [31:0] force_code, input logic [31:0] disp_code,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {disp_code, force_code};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // magnitude to a sample code, sign picked at random
    function automatic logic [31:0] signed_code(logic [63:0] mag);
        if (mag >= FULL_SCALE)
            return FULL_CODE;
        if ($urandom_range(3) == 0)
            return 32'd0 - mag[31:0];
        return mag[31:0];
    endfunction

    task automatic drive_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [THRESH_W-1:0] thresh,
                             input logic [AREA_W-1:0] area);
        drive_reg(CFG_MODE, {31'd0, mode});
        drive_reg(CFG_THRESH, {1'b0, thresh});
        drive_reg(CFG_AREA, area);
        cfg_wr_en  <= 1'b0;
        cur_mode   = mode;
        cur_thresh = thresh;
    endtask

    task automatic configure_random();
        logic [THRESH_W-1:0] thresh;
        logic [AREA_W-1:0]   area;
        case ($urandom_range(4))
            0:       thresh = '0;
            1:       thresh = 31'h7FFF_FFFF;
            default: thresh = 31'($urandom >> $urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
            0:       area = '0;
            1:       area = 32'd1;
            2:       area = 32'hFFFF_FFFF;
            3, 4:    area = AREA_RESET;
            default: area = $urandom >> $urandom_range(0, 24);
        endcase
        configure(1'($urandom_range(1)), thresh, area);
    endtask

    // wait for every outstanding result, then let the core settle
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // loading curve: rise to a peak, soften down to a tail force
    task automatic send_curve_run(output int unsigned count);
        int unsigned n;
        int unsigned peak_at;
        int unsigned bump_at;
        int unsigned i;
        logic [63:0] peak;
        logic [63:0] tail;
        logic [63:0] f;
        logic [63:0] d;
        logic [63:0] step;
        logic [63:0] mask;
        logic [31:0] f0;
        logic [31:0] d0;
        n = ($urandom_range(11) == 0) ? 1 : $urandom_range(2, 12);
        if (cur_mode)
            peak = {33'd0, cur_thresh} + 64'd1
                   + 64'($urandom & ((32'd1 << $urandom_range(4, 30)) - 32'd1));
        else
            peak = 64'($urandom & ((32'd1 << $urandom_range(4, 31)) - 32'd1));
        if (peak > FULL_SCALE)
            peak = FULL_SCALE;
        if ($urandom_range(5) == 0)
            tail = peak;                          // ends still loaded
        else if (cur_mode)
            tail = 64'($urandom_range({1'b0, cur_thresh}));
        else
            tail = peak >> $urandom_range(1, 8);
        peak_at = (n > 2) ? $urandom_range(1, n - 2) : 1;
        bump_at = (n > 1 && $urandom_range(4) == 0) ? $urandom_range(1, n - 1) : 0;
        mask    = (64'd1 << $urandom_range(0, 28)) - 64'd1;
        if ($urandom_range(9) == 0) begin
            f0 = $urandom;
            d0 = $urandom;
        end else begin
            f0 = '0;
            d0 = '0;
        end
        send_sample(f0, d0, n == 1);
        d = '0;
        for (i = 1; i < n; i++) begin
            if (i <= peak_at)
                f = peak * 64'(i) / 64'(peak_at);
            else
                f = peak - (peak - tail) * 64'(i - peak_at) / 64'(n - 1 - peak_at);
            if (i == bump_at)
                f = peak;                         // reload after softening
            step = 64'($urandom) & mask;
            if ($urandom_range(9) == 0)
                d = (step > d) ? 64'd0 : d - step;
            else
                d = (d + step > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : d + step;
            send_sample(signed_code(f), signed_code(d), i == n - 1);
        end
        count = n;
    endtask

    task automatic send_noise_run(output int unsigned count);
        int unsigned n;
        int unsigned i;
        logic        zero_first;
        n          = $urandom_range(1, 8);
        zero_first = 1'($urandom_range(1));
        for (i = 0; i < n; i++) begin
            if (i == 0 && zero_first)
                send_sample(32'd0, 32'd0, n == 1);
            else
                send_sample($urandom, $urandom, i == n - 1);
        end
        count = n;
    endtask

    initial begin
        int          phase;
        int unsigned sent;
        int unsigned count;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // whole curve, registers at reset values
        send_sample(32'd0, 32'd0, 1'b1);
        send_sample(FULL_CODE, 32'h7FFF_FFFF, 1'b1);
        // two full-force loading strokes overflow the integral
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(FULL_CODE, 32'd0, 1'b0);
        send_sample(FULL_CODE, FULL_CODE, 1'b0);
        send_sample(32'd0, FULL_CODE, 1'b0);
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(FULL_CODE, 32'd0, 1'b0);
        send_sample(FULL_CODE, FULL_CODE, 1'b1);
        // unloading under full force, negative energy
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(32'd0, FULL_CODE, 1'b0);
        send_sample(FULL_CODE, FULL_CODE, 1'b0);
        send_sample(FULL_CODE, 32'd0, 1'b1);
        drain_results();

        configure(1'b0, 31'd0, 32'd0);
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(32'h0001_8000, 32'h0002_0000, 1'b1);
        drain_results();

        configure(1'b1, 31'h0001_0000, 32'hFFFF_FFFF);
        // drops through the threshold on the final sample
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(32'h0003_0000, 32'h0001_0000, 1'b0);
        send_sample(32'hFFFF_4000, 32'h0002_0000, 1'b1);
        // never above the threshold
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(32'h0000_8000, 32'h0000_1000, 1'b1);
        // off-origin start outranks the final force above
        send_sample(32'd1, 32'd0, 1'b0);
        send_sample(32'h0003_0000, 32'd5, 1'b1);
        drain_results();

        // crossing from the largest magnitude down onto the threshold itself
        configure(1'b1, 31'h7FFF_FFFF, 32'd1);
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(FULL_CODE, 32'h0000_0100, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h0000_0200, 1'b1);
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                send_idle_pct = 26;
                recv_idle_pct <= 48;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 48;
                recv_idle_pct <= 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            configure_random();
            if (phase == PHASES - 4)
                hold_reqs <= hold_reqs + 1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(4) == 0)
                    send_noise_run(count);
                else
                    send_curve_run(count);
                sent += count;
            end
            drain_results();
        end

        sb.report_leftover();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
